// File: rtl/rvdec_pkg.sv
package rvdec_pkg;

    // major opcodes, bits 6:0
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_STORE  = 7'h23;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SR  = 3'd5;

    typedef enum logic [5:0] {
        MN_ADD   = 6'd0,  MN_SUB   = 6'd1,  MN_SLL   = 6'd2,  MN_SLT   = 6'd3,
        MN_SLTU  = 6'd4,  MN_XOR   = 6'd5,  MN_SRL   = 6'd6,  MN_SRA   = 6'd7,
        MN_OR    = 6'd8,  MN_AND   = 6'd9,  MN_LB    = 6'd10, MN_LH    = 6'd11,
        MN_LW    = 6'd12, MN_LBU   = 6'd13, MN_LHU   = 6'd14, MN_JALR  = 6'd15,
        MN_ADDI  = 6'd16, MN_SLTI  = 6'd17, MN_SLTIU = 6'd18, MN_XORI  = 6'd19,
        MN_ORI   = 6'd20, MN_ANDI  = 6'd21, MN_SLLI  = 6'd22, MN_SRLI  = 6'd23,
        MN_SRAI  = 6'd24, MN_LUI   = 6'd25, MN_AUIPC = 6'd26, MN_JAL   = 6'd27,
        MN_BEQ   = 6'd28, MN_BNE   = 6'd29, MN_BLT   = 6'd30, MN_BGE   = 6'd31,
        MN_BLTU  = 6'd32, MN_BGEU  = 6'd33, MN_SB    = 6'd34, MN_SH    = 6'd35,
        MN_SW    = 6'd36
    } t_mnem;

    typedef enum logic [2:0] {
        FM_R    = 3'd0,
        FM_MEM  = 3'd1,
        FM_IALU = 3'd2,
        FM_U    = 3'd3,
        FM_J    = 3'd4,
        FM_B    = 3'd5,
        FM_S    = 3'd6
    } t_form;

    typedef t_mnem t_mnem_tab [8];

    // indexed by funct3
    localparam t_mnem_tab R_MNEM = '{
        MN_ADD, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_OR, MN_AND
    };
    localparam t_mnem_tab OPIMM_MNEM = '{
        MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI, MN_ORI, MN_ANDI
    };
    localparam t_mnem_tab LOAD_MNEM = '{
        MN_LB, MN_LH, MN_LW, MN_LB, MN_LBU, MN_LHU, MN_LB, MN_LB
    };
    localparam t_mnem_tab BRANCH_MNEM = '{
        MN_BEQ, MN_BNE, MN_BEQ, MN_BEQ, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU
    };
    localparam t_mnem_tab STORE_MNEM = '{
        MN_SB, MN_SH, MN_SW, MN_SB, MN_SB, MN_SB, MN_SB, MN_SB
    };

    // legal funct3 codes per opcode, bit n for funct3 == n
    localparam logic [7:0] LOAD_F3_OK   = 8'b0011_0111;
    localparam logic [7:0] BRANCH_F3_OK = 8'b1111_0011;
    localparam logic [7:0] STORE_F3_OK  = 8'b0000_0111;

    typedef struct packed {
        logic               recognised;
        t_mnem              mnemonic;
        t_form              operand_form;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
    } t_dec;

endpackage

// File: rtl/rvdec_in_if.sv
interface rvdec_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

// File: rtl/rvdec_out_if.sv
interface rvdec_out_if;
    logic               valid;
    logic               ready;
    logic               recognised;
    logic [5:0]         mnemonic;
    logic [2:0]         operand_form;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;

    modport source (
        output valid, output recognised, output mnemonic, output operand_form,
        output dest_reg, output src1_reg, output src2_reg, output immediate,
        input ready
    );
    modport sink (
        input valid, input recognised, input mnemonic, input operand_form,
        input dest_reg, input src1_reg, input src2_reg, input immediate,
        output ready
    );
endinterface

// File: rtl/rvdec_core.sv
module rvdec_core (
    input  logic [31:0]      i_word,
    output rvdec_pkg::t_dec  o_dec
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] imm_sh;
    logic        ok;
    rvdec_pkg::t_dec d;

    assign opc = i_word[6:0];
    assign rd  = i_word[11:7];
    assign f3  = i_word[14:12];
    assign rs1 = i_word[19:15];
    assign rs2 = i_word[24:20];
    assign f7  = i_word[31:25];

    assign imm_i  = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s  = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b  = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                     i_word[11:8], 1'b0};
    assign imm_u  = {i_word[31:12], 12'd0};
    assign imm_j  = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                     i_word[30:21], 1'b0};
    assign imm_sh = {27'd0, rs2};

    always_comb begin
        d = '0;
        d.recognised = 1'b1;
        ok = 1'b0;
        unique case (opc) inside
            rvdec_pkg::OPC_OP: begin
                d.operand_form = rvdec_pkg::FM_R;
                d.dest_reg = rd;
                d.src1_reg = rs1;
                d.src2_reg = rs2;
                if (f7 == rvdec_pkg::F7_BASE) begin
                    ok = 1'b1;
                    d.mnemonic = rvdec_pkg::R_MNEM[f3];
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_ADD) begin
                    ok = 1'b1;
                    d.mnemonic = rvdec_pkg::MN_SUB;
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_SR) begin
                    ok = 1'b1;
                    d.mnemonic = rvdec_pkg::MN_SRA;
                end
            end
            rvdec_pkg::OPC_LOAD: begin
                ok = rvdec_pkg::LOAD_F3_OK[f3];
                d.mnemonic = rvdec_pkg::LOAD_MNEM[f3];
                d.operand_form = rvdec_pkg::FM_MEM;
                d.dest_reg = rd;
                d.src1_reg = rs1;
                d.immediate = imm_i;
            end
            rvdec_pkg::OPC_JALR: begin
                ok = (f3 == rvdec_pkg::F3_ADD);
                d.mnemonic = rvdec_pkg::MN_JALR;
                d.operand_form = rvdec_pkg::FM_MEM;
                d.dest_reg = rd;
                d.src1_reg = rs1;
                d.immediate = imm_i;
            end
            rvdec_pkg::OPC_OPIMM: begin
                d.operand_form = rvdec_pkg::FM_IALU;
                d.dest_reg = rd;
                d.src1_reg = rs1;
                d.mnemonic = rvdec_pkg::OPIMM_MNEM[f3];
                if (f3 == rvdec_pkg::F3_SLL) begin
                    ok = (f7 == rvdec_pkg::F7_BASE);
                    d.immediate = imm_sh;
                end else if (f3 == rvdec_pkg::F3_SR) begin
                    ok = (f7 == rvdec_pkg::F7_BASE) || (f7 == rvdec_pkg::F7_ALT);
                    if (f7 == rvdec_pkg::F7_ALT) begin
                        d.mnemonic = rvdec_pkg::MN_SRAI;
                    end
                    d.immediate = imm_sh;
                end else begin
                    ok = 1'b1;
                    d.immediate = imm_i;
                end
            end
            rvdec_pkg::OPC_LUI, rvdec_pkg::OPC_AUIPC: begin
                ok = 1'b1;
                d.mnemonic = (opc == rvdec_pkg::OPC_LUI) ? rvdec_pkg::MN_LUI
                                                         : rvdec_pkg::MN_AUIPC;
                d.operand_form = rvdec_pkg::FM_U;
                d.dest_reg = rd;
                d.immediate = imm_u;
            end
            rvdec_pkg::OPC_JAL: begin
                ok = 1'b1;
                d.mnemonic = rvdec_pkg::MN_JAL;
                d.operand_form = rvdec_pkg::FM_J;
                d.dest_reg = rd;
                d.immediate = imm_j;
            end
            rvdec_pkg::OPC_BRANCH: begin
                ok = rvdec_pkg::BRANCH_F3_OK[f3];
                d.mnemonic = rvdec_pkg::BRANCH_MNEM[f3];
                d.operand_form = rvdec_pkg::FM_B;
                d.src1_reg = rs1;
                d.src2_reg = rs2;
                d.immediate = imm_b;
            end
            rvdec_pkg::OPC_STORE: begin
                ok = rvdec_pkg::STORE_F3_OK[f3];
                d.mnemonic = rvdec_pkg::STORE_MNEM[f3];
                d.operand_form = rvdec_pkg::FM_S;
                d.src1_reg = rs1;
                d.src2_reg = rs2;
                d.immediate = imm_s;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        // unknown words report all-zero fields
        if (!ok) begin
            d = '0;
        end
    end

    assign o_dec = d;

endmodule

// File: rtl/rv32i_instruction_decoder.sv
// RV32I instruction decoder.
// i_instr carries one 32-bit instruction word per item (valid/ready, taken
// at a clock edge with both high). o_dec returns one decoded item per word:
// recognised flag, mnemonic code, operand format, rd/rs1/rs2 and the
// sign-extended immediate of the format (shamt for shifts). Unknown words
// come back with every field zero.
// Two register stages: the word is captured in an input register, decoded
// by a short combinational network, and held in the result register. Throughput
// is one item per cycle, set by the two pipeline registers that each advance
// every cycle when the stage ahead is empty or draining.
// When the receiver holds o_dec.ready low the result holds, the input stage
// still takes one more word if it is empty, and then i_instr.ready drops
// until the result is taken. Reset (i_rst_n low, synchronous) empties both
// stages; no state survives beyond the items in flight.
module rv32i_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvdec_in_if.sink    i_instr,
    rvdec_out_if.source o_dec
);

    logic            r_s1_valid;
    logic            n_s1_valid;
    logic [31:0]     r_s1_word;
    logic            r_out_valid;
    logic            n_out_valid;
    rvdec_pkg::t_dec r_out;
    rvdec_pkg::t_dec dec;
    logic            out_free;
    logic            in_take;

    assign out_free = !r_out_valid || o_dec.ready;
    assign i_instr.ready = !r_s1_valid || out_free;
    assign in_take = i_instr.valid && i_instr.ready;

    assign n_s1_valid  = i_instr.ready ? i_instr.valid : r_s1_valid;
    assign n_out_valid = out_free ? r_s1_valid : r_out_valid;

    rvdec_core u_core (
        .i_word (r_s1_word),
        .o_dec  (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_word <= i_instr.instr_word;
        end
        if (out_free && r_s1_valid) begin
            r_out <= dec;
        end
    end

    assign o_dec.valid        = r_out_valid;
    assign o_dec.recognised   = r_out.recognised;
    assign o_dec.mnemonic     = r_out.mnemonic;
    assign o_dec.operand_form = r_out.operand_form;
    assign o_dec.dest_reg     = r_out.dest_reg;
    assign o_dec.src1_reg     = r_out.src1_reg;
    assign o_dec.src2_reg     = r_out.src2_reg;
    assign o_dec.immediate    = r_out.immediate;

endmodule

// File: tb/sv/tb.sv
module tb;
    import rvdec_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1500;
    localparam int CALM_FROM    = 1350;
    localparam int HOLD_AT      = 400;

    class decode_scoreboard;
        t_dec        pending[$];
        logic [31:0] pending_words[$];
        int          errors;

        // expected decoding of one instruction word
        function t_dec decode_word(logic [31:0] w);
            t_dec        d;
            t_mnem       ops [8];
            logic [7:0]  legal;
            logic [2:0]  f3;
            logic [6:0]  f7;
            logic [31:0] imm_i;
            logic        ok;
            d = '0;
            f3 = w[14:12];
            f7 = w[31:25];
            imm_i = {{20{w[31]}}, w[31:20]};
            ok = 1'b1;
            d.dest_reg = w[11:7];
            d.src1_reg = w[19:15];
            d.src2_reg = w[24:20];
            case (w[6:0])
                OPC_OP: begin
                    ops = '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_OR, MN_AND};
                    d.operand_form = FM_R;
                    if (f7 == F7_BASE) d.mnemonic = ops[f3];
                    else if (f7 == F7_ALT && f3 == F3_ADD) d.mnemonic = MN_SUB;
                    else if (f7 == F7_ALT && f3 == F3_SR) d.mnemonic = MN_SRA;
                    else ok = 1'b0;
                end
                OPC_LOAD, OPC_JALR: begin
                    ops = '{MN_LB, MN_LH, MN_LW, MN_LB, MN_LBU, MN_LHU, MN_LB, MN_LB};
                    legal = 8'b0011_0111;
                    d.operand_form = FM_MEM;
                    d.immediate = imm_i;
                    d.src2_reg = '0;
                    // jalr takes funct3 zero only
                    if (w[6:0] == OPC_JALR) begin
                        ok = (f3 == F3_ADD);
                        d.mnemonic = MN_JALR;
                    end else begin
                        ok = legal[f3];
                        d.mnemonic = ops[f3];
                    end
                end
                OPC_OPIMM: begin
                    ops = '{MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU,
                            MN_XORI, MN_SRLI, MN_ORI, MN_ANDI};
                    d.operand_form = FM_IALU;
                    d.src2_reg = '0;
                    d.mnemonic = ops[f3];
                    d.immediate = imm_i;
                    if (f3 == F3_SLL || f3 == F3_SR) begin
                        d.immediate = {27'b0, w[24:20]};
                        if (f3 == F3_SR && f7 == F7_ALT) d.mnemonic = MN_SRAI;
                        else ok = (f7 == F7_BASE);
                    end
                end
                OPC_LUI, OPC_AUIPC: begin
                    d.mnemonic = (w[6:0] == OPC_LUI) ? MN_LUI : MN_AUIPC;
                    d.operand_form = FM_U;
                    d.immediate = {w[31:12], 12'b0};
                    d.src1_reg = '0;
                    d.src2_reg = '0;
                end
                OPC_JAL: begin
                    d.mnemonic = MN_JAL;
                    d.operand_form = FM_J;
                    d.immediate = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                    d.src1_reg = '0;
                    d.src2_reg = '0;
                end
                OPC_BRANCH: begin
                    ops = '{MN_BEQ, MN_BNE, MN_BEQ, MN_BEQ, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};
                    legal = 8'b1111_0011;
                    ok = legal[f3];
                    d.mnemonic = ops[f3];
                    d.operand_form = FM_B;
                    d.immediate = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                    d.dest_reg = '0;
                end
                OPC_STORE: begin
                    ops = '{MN_SB, MN_SH, MN_SW, MN_SB, MN_SB, MN_SB, MN_SB, MN_SB};
                    legal = 8'b0000_0111;
                    ok = legal[f3];
                    d.mnemonic = ops[f3];
                    d.operand_form = FM_S;
                    d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                    d.dest_reg = '0;
                end
                default: ok = 1'b0;
            endcase
            if (!ok) d = '0;
            d.recognised = ok;
            return d;
        endfunction

        function void note_word(logic [31:0] w);
            pending.push_back(decode_word(w));
            pending_words.push_back(w);
        endfunction

        function void compare_field(string name, logic [31:0] w,
                                    logic [31:0] exp_val, logic [31:0] act_val);
            if (exp_val !== act_val) begin
                $display("%0t: word %h %s expected %h actual %h",
                         $time, w, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(t_dec got);
            t_dec        want;
            logic [31:0] w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            w = pending_words.pop_front();
            compare_field("recognised", w, 32'(want.recognised), 32'(got.recognised));
            compare_field("mnemonic", w, 32'(want.mnemonic), 32'(got.mnemonic));
            compare_field("operand_form", w, 32'(want.operand_form),
                          32'(got.operand_form));
            compare_field("dest_reg", w, 32'(want.dest_reg), 32'(got.dest_reg));
            compare_field("src1_reg", w, 32'(want.src1_reg), 32'(got.src1_reg));
            compare_field("src2_reg", w, 32'(want.src2_reg), 32'(got.src2_reg));
            compare_field("immediate", w, want.immediate, got.immediate);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rvdec_in_if  instr_if ();
    rvdec_out_if dec_if ();

    rv32i_instruction_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_if),
        .o_dec   (dec_if)
    );

    decode_scoreboard sb;
    int  cycles = 0;
    int  send_odds = 0;
    int  take_odds = 0;
    bit  calm = 1'b0;
    bit  hold_off_req = 1'b0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // accepted items on both sides, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && instr_if.valid && instr_if.ready)
            sb.note_word(instr_if.instr_word);
        if (i_rst_n && dec_if.valid && dec_if.ready)
            sb.check_result(t_dec'({dec_if.recognised, dec_if.mnemonic, dec_if.operand_form,
                                    dec_if.dest_reg, dec_if.src1_reg, dec_if.src2_reg,
                                    dec_if.immediate}));
    end

    // mostly well-formed words with random fields, some plain noise
    function automatic logic [31:0] random_word();
        logic [6:0]  majors [9];
        logic [31:0] w;
        logic [2:0]  f3;
        int unsigned pick;
        majors = '{OPC_OP, OPC_LOAD, OPC_JALR, OPC_OPIMM, OPC_LUI,
                   OPC_AUIPC, OPC_JAL, OPC_BRANCH, OPC_STORE};
        w = $urandom();
        if ($urandom_range(0, 9) == 0) return w;
        w[6:0] = majors[$urandom_range(0, 8)];
        f3 = w[14:12];
        if (w[6:0] == OPC_JALR && $urandom_range(0, 3) != 0) w[14:12] = F3_ADD;
        // funct7 selects the operation here, so mostly steer it to the legal values
        if (w[6:0] == OPC_OP || (w[6:0] == OPC_OPIMM && (f3 == F3_SLL || f3 == F3_SR))) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) w[31:25] = F7_BASE;
            else if (pick < 9) w[31:25] = F7_ALT;
        end
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [31:0] w);
        int gap;
        if (!calm && $urandom_range(0, 15) < send_odds) begin
            gap = $urandom_range(1, 9);
            instr_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        instr_if.valid <= 1'b1;
        instr_if.instr_word <= w;
        do @(posedge i_clk); while (!instr_if.ready);
        @(negedge i_clk);
    endtask

    initial begin : receiver
        int gap;
        int decisions;
        decisions = 0;
        dec_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (decisions % 50 == 0) take_odds = $urandom_range(0, 2) * 4;
            decisions++;
            if (hold_off_req) begin
                // long hold so the pipeline fills and backs up the input
                hold_off_req = 1'b0;
                dec_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 15) < take_odds) begin
                gap = $urandom_range(1, 9);
                dec_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end else begin
                dec_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] directed_words [27];
        sb = new();
        instr_if.valid = 1'b0;
        instr_if.instr_word = '0;
        directed_words = '{
            32'h0000_0000,  // all zero, unknown opcode
            32'hFFFF_FFFF,  // all ones, unknown opcode
            32'h01FF_8FB3,  // add, every register 31
            32'h400F_8033,  // sub
            32'h4053_53B3,  // sra
            32'h0200_0033,  // R type, funct7 not base or alt
            32'h4000_1033,  // alt funct7 with sll funct3
            32'hFFF0_0003,  // lb, offset -1
            32'h7FFF_DF83,  // lhu, largest offset
            32'h0000_3003,  // load with undefined funct3
            32'h8000_0067,  // jalr, most negative offset
            32'h0000_1067,  // jalr with nonzero funct3
            32'hFFF0_3013,  // sltiu, immediate -1
            32'h01F0_1013,  // slli shamt 31
            32'h41F0_1013,  // slli with alt funct7
            32'h01F0_5013,  // srli
            32'h41F0_5013,  // srai
            32'h0200_5013,  // shift right with stray funct7
            32'hFFFF_F037,  // lui, upper bits all set
            32'h8000_0F97,  // auipc
            32'h8000_006F,  // jal, most negative offset
            32'hFFFF_FFEF,  // jal, offset -2
            32'h7E00_0FE3,  // beq, largest offset
            32'h0000_2063,  // branch with undefined funct3
            32'hFFFF_FFE3,  // bgeu, offset -2
            32'hFE00_2FA3,  // sw, offset -1
            32'h0000_3023   // store with undefined funct3
        };
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_words[k])
            send_word(directed_words[k]);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) send_odds = $urandom_range(0, 2) * 4;
            if (n == HOLD_AT) hold_off_req = 1'b1;
            if (n == CALM_FROM) calm = 1'b1;
            send_word(random_word());
        end
        instr_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
